### rtl/rpsd_pkg.sv
`timescale 1ns / 1ps
// rpsd_pkg: item types and helpers for the rise/peak/set detector
// no dependencies; imported by rpsd_track and rise_peak_set_detector_core

package rpsd_pkg;

  localparam int unsigned ELEV_W = 18;
  localparam int unsigned TIME_W = 18;

  typedef logic signed [ELEV_W-1:0] elev_t;
  typedef logic [TIME_W-1:0]        stamp_t;
  typedef logic [ELEV_W-1:0]        mag_t;

  typedef struct packed {
    elev_t  elevation;
    stamp_t time_of_day;
    logic   last_sample;
  } in_item_t;

  typedef struct packed {
    logic   rise_found;
    stamp_t rise_time;
    stamp_t peak_time;
    logic   set_found;
    stamp_t set_time;
  } out_item_t;

  // distance from zero; the most negative code maps to its unsigned magnitude
  function automatic mag_t elev_mag(elev_t v);
    mag_t m;
    m = v[ELEV_W-1] ? mag_t'(-v) : mag_t'(v);
    return m;
  endfunction

endpackage

### rtl/rpsd_track.sv
`timescale 1ns / 1ps
// rpsd_track: run state (previous sample, peak, rise and set marks) and result
// depends on rpsd_pkg

module rpsd_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  rpsd_pkg::in_item_t item,
  output rpsd_pkg::out_item_t result
);
  import rpsd_pkg::*;

  logic   have_prev_r, have_prev_nxt;
  elev_t  prev_elev_r, prev_elev_nxt;
  stamp_t prev_time_r, prev_time_nxt;
  elev_t  peak_elev_r, peak_elev_nxt;
  stamp_t peak_stamp_r, peak_stamp_nxt;
  logic   rise_seen_r, rise_seen_nxt;
  stamp_t rise_stamp_r, rise_stamp_nxt;
  logic   set_seen_r, set_seen_nxt;
  stamp_t set_stamp_r, set_stamp_nxt;

  // updated state before the end-of-run clear
  elev_t  upd_peak_elev;
  stamp_t upd_peak_stamp;
  logic   upd_rise_seen;
  stamp_t upd_rise_stamp;
  logic   upd_set_seen;
  stamp_t upd_set_stamp;

  mag_t   mag_cur;
  mag_t   mag_prev;
  logic   cur_neg;
  logic   prev_neg;

  always_comb begin
    mag_cur  = elev_mag(item.elevation);
    mag_prev = elev_mag(prev_elev_r);
    cur_neg  = item.elevation[ELEV_W-1];
    prev_neg = prev_elev_r[ELEV_W-1];

    upd_peak_elev  = peak_elev_r;
    upd_peak_stamp = peak_stamp_r;
    upd_rise_seen  = rise_seen_r;
    upd_rise_stamp = rise_stamp_r;
    upd_set_seen   = set_seen_r;
    upd_set_stamp  = set_stamp_r;

    if (!have_prev_r || (item.elevation > peak_elev_r)) begin
      upd_peak_elev  = item.elevation;
      upd_peak_stamp = item.time_of_day;
    end
    // rising crossing: tie keeps the earlier sample
    if (have_prev_r && !rise_seen_r && prev_neg && !cur_neg) begin
      upd_rise_seen  = 1'b1;
      upd_rise_stamp = (mag_cur < mag_prev) ? item.time_of_day : prev_time_r;
    end
    // falling crossing: tie keeps the later sample
    if (have_prev_r && !set_seen_r && !prev_neg && cur_neg) begin
      upd_set_seen  = 1'b1;
      upd_set_stamp = (mag_prev < mag_cur) ? prev_time_r : item.time_of_day;
    end

    result.rise_found = upd_rise_seen;
    result.rise_time  = upd_rise_seen ? upd_rise_stamp : '0;
    result.peak_time  = upd_peak_stamp;
    result.set_found  = upd_set_seen;
    result.set_time   = upd_set_seen ? upd_set_stamp : '0;

    if (item.last_sample) begin
      have_prev_nxt  = 1'b0;
      prev_elev_nxt  = '0;
      prev_time_nxt  = '0;
      peak_elev_nxt  = '0;
      peak_stamp_nxt = '0;
      rise_seen_nxt  = 1'b0;
      rise_stamp_nxt = '0;
      set_seen_nxt   = 1'b0;
      set_stamp_nxt  = '0;
    end else begin
      have_prev_nxt  = 1'b1;
      prev_elev_nxt  = item.elevation;
      prev_time_nxt  = item.time_of_day;
      peak_elev_nxt  = upd_peak_elev;
      peak_stamp_nxt = upd_peak_stamp;
      rise_seen_nxt  = upd_rise_seen;
      rise_stamp_nxt = upd_rise_stamp;
      set_seen_nxt   = upd_set_seen;
      set_stamp_nxt  = upd_set_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      prev_elev_r  <= '0;
      prev_time_r  <= '0;
      peak_elev_r  <= '0;
      peak_stamp_r <= '0;
      rise_seen_r  <= 1'b0;
      rise_stamp_r <= '0;
      set_seen_r   <= 1'b0;
      set_stamp_r  <= '0;
    end else if (step) begin
      have_prev_r  <= have_prev_nxt;
      prev_elev_r  <= prev_elev_nxt;
      prev_time_r  <= prev_time_nxt;
      peak_elev_r  <= peak_elev_nxt;
      peak_stamp_r <= peak_stamp_nxt;
      rise_seen_r  <= rise_seen_nxt;
      rise_stamp_r <= rise_stamp_nxt;
      set_seen_r   <= set_seen_nxt;
      set_stamp_r  <= set_stamp_nxt;
    end
  end

endmodule

### rtl/rise_peak_set_detector_core.sv
`timescale 1ns / 1ps
// rise_peak_set_detector_core: top level, input register, result register
// depends on rpsd_pkg and rpsd_track

// Takes one elevation sample per cycle (signed thousandths of a degree plus
// an HHMMSS stamp) and, on the item flagged last_sample, delivers one result:
// the stamp of the first maximum, and the stamps of the first rising and
// first falling zero crossings, each taken from whichever neighbouring sample
// is closer to zero (rise keeps the earlier one on a tie, set the later one).
// The run state then returns to its reset values. Throughput is one item per
// cycle; an item sits in the input register after the edge that accepts it,
// and its result is loaded into the result register when that item moves on
// (the crossing and peak compares sit between the two registers). Items that
// are not last never wait on the result side; only a last item meets
// back-pressure, when the previous result is still held.

module rise_peak_set_detector_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpsd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rpsd_pkg::out_item_t out_item
);
  import rpsd_pkg::*;

  // input register
  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  out_item_t result;
  logic      advance;
  logic      emit;

  // a non-last item only updates run state, so it moves regardless of out_ready
  assign advance = in_valid_r &&
                   (!in_item_r.last_sample || !out_valid_r || out_ready);
  assign emit    = advance && in_item_r.last_sample;
  assign in_ready = !in_valid_r || advance;

  assign in_valid_nxt  = in_ready ? in_valid : in_valid_r;
  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  rpsd_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (emit) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // a last item that moves on always shows up as a result next cycle
  a_emit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid)
    else $error("last item advanced without a result");

  // input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && in_item_r.last_sample && out_valid_r && !out_ready))
    else $error("input stalled without output back-pressure");

  // a missing crossing reports a zero stamp
  a_zero_stamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.rise_found || out_item.rise_time == '0) &&
                   (out_item.set_found || out_item.set_time == '0)))
    else $error("stamp reported for a crossing that was not seen");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for rise_peak_set_detector_core, directed runs then random runs
// depends on rpsd_pkg and rise_peak_set_detector_core

module tb_top;
  import rpsd_pkg::*;

  localparam int unsigned  HALF_PERIOD_NS = 6;
  localparam int unsigned  RESET_CYCLES   = 7;
  localparam int unsigned  RANDOM_SAMPLES = 1350;
  localparam int unsigned  DRAIN_GUARD    = 50000;
  localparam int unsigned  SETTLE_CYCLES  = 10;
  localparam longint       TIMEOUT_NS     = 5_000_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  rise_peak_set_detector_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #(HALF_PERIOD_NS) clk = ~clk;

  // run state mirrored from the block, elevations held as plain ints
  bit     run_open;
  int     prev_elev;
  stamp_t prev_stamp;
  int     max_elev;
  stamp_t max_stamp;
  bit     rise_hit;
  stamp_t rise_at;
  bit     set_hit;
  stamp_t set_at;

  out_item_t run_reports[$];

  int unsigned mismatches;
  int unsigned samples_taken;
  int unsigned reports_checked;
  int unsigned rise_reports;
  int unsigned set_reports;
  int unsigned random_sent;
  int          burst_left;

  function automatic int dist_from_zero(int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic clear_run();
    run_open   = 1'b0;
    prev_elev  = 0;
    prev_stamp = '0;
    max_elev   = 0;
    max_stamp  = '0;
    rise_hit   = 1'b0;
    rise_at    = '0;
    set_hit    = 1'b0;
    set_at     = '0;
  endtask

  // fold one accepted sample into the run; a last sample queues the report
  task automatic fold_sample(in_item_t s);
    int        el;
    out_item_t rep;
    el = $signed(s.elevation);
    if (!run_open) begin
      max_elev  = el;
      max_stamp = s.time_of_day;
    end else begin
      if (el > max_elev) begin
        max_elev  = el;
        max_stamp = s.time_of_day;
      end
      // rise: tie keeps the earlier sample
      if (!rise_hit && prev_elev < 0 && el >= 0) begin
        rise_hit = 1'b1;
        rise_at  = (dist_from_zero(el) < dist_from_zero(prev_elev)) ? s.time_of_day : prev_stamp;
      end
      // set: tie keeps the later sample
      if (!set_hit && prev_elev >= 0 && el < 0) begin
        set_hit = 1'b1;
        set_at  = (dist_from_zero(prev_elev) < dist_from_zero(el)) ? prev_stamp : s.time_of_day;
      end
    end
    run_open   = 1'b1;
    prev_elev  = el;
    prev_stamp = s.time_of_day;
    if (s.last_sample) begin
      rep.rise_found = rise_hit;
      rep.rise_time  = rise_hit ? rise_at : '0;
      rep.peak_time  = max_stamp;
      rep.set_found  = set_hit;
      rep.set_time   = set_hit ? set_at : '0;
      run_reports = {run_reports, rep};
      clear_run();
    end
  endtask

  task automatic check_report(out_item_t got);
    out_item_t want;
    if (run_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing expected: rise %0b/%0d peak %0d set %0b/%0d",
                 $realtime, got.rise_found, got.rise_time, got.peak_time,
                 got.set_found, got.set_time);
    end else begin
      want = run_reports.pop_front();
      reports_checked++;
      if (want.rise_found) rise_reports++;
      if (want.set_found) set_reports++;
      if (got.rise_found !== want.rise_found || got.rise_time !== want.rise_time ||
          got.peak_time !== want.peak_time || got.set_found !== want.set_found ||
          got.set_time !== want.set_time) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch on result %0d", $realtime, reports_checked);
          $display("  expected rise %0b/%0d peak %0d set %0b/%0d", want.rise_found,
                   want.rise_time, want.peak_time, want.set_found, want.set_time);
          $display("  actual   rise %0b/%0d peak %0d set %0b/%0d", got.rise_found,
                   got.rise_time, got.peak_time, got.set_found, got.set_time);
        end
      end
    end
  endtask

  // both handshakes are sampled with their pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_report(out_item);
      if (in_valid && in_ready) begin
        samples_taken++;
        fold_sample(in_item);
      end
    end
  end

  // receiver: a mode drawn at random, from always ready to long stalls
  int unsigned rx_cycle;
  int unsigned rx_mode;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 150 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= (rx_cycle % 24 == 23);
    endcase
  end

  function automatic in_item_t make_sample(int el, int unsigned t, bit last);
    in_item_t s;
    s.elevation   = elev_t'(el);
    s.time_of_day = stamp_t'(t);
    s.last_sample = last;
    return s;
  endfunction

  // hold the item until taken; then either keep the burst going or idle a while
  task automatic send_sample(in_item_t s);
    int unsigned gap;
    in_valid <= 1'b1;
    in_item  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4:          gap = $urandom_range(5, 20);
        default:    gap = $urandom_range(1, 4);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // idle the input, then wait until every result is back or the guard runs out
  task automatic wait_reports_drained();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (run_reports.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic test_single_samples();
    send_sample(make_sample(-90000, 0, 1'b1));
    send_sample(make_sample(90000, 235959, 1'b1));
  endtask

  task automatic test_crossing_ties();
    // equal distance on both crossings
    send_sample(make_sample(-5, 100, 1'b0));
    send_sample(make_sample(5, 101, 1'b0));
    send_sample(make_sample(9, 102, 1'b0));
    send_sample(make_sample(3, 103, 1'b0));
    send_sample(make_sample(-3, 104, 1'b0));
    send_sample(make_sample(-8, 105, 1'b1));
    // rise onto zero, set off zero, second rise ignored
    send_sample(make_sample(-4, 200, 1'b0));
    send_sample(make_sample(0, 201, 1'b0));
    send_sample(make_sample(-7, 202, 1'b0));
    send_sample(make_sample(3, 203, 1'b1));
    // earlier sample closer at rise, repeated maximum keeps the first
    send_sample(make_sample(-1, 300, 1'b0));
    send_sample(make_sample(50, 301, 1'b0));
    send_sample(make_sample(50, 302, 1'b0));
    send_sample(make_sample(40, 303, 1'b0));
    send_sample(make_sample(-90, 304, 1'b1));
  endtask

  task automatic test_no_crossings();
    send_sample(make_sample(10, 400, 1'b0));
    send_sample(make_sample(20, 401, 1'b0));
    send_sample(make_sample(20, 402, 1'b0));
    send_sample(make_sample(5, 403, 1'b1));
    send_sample(make_sample(-100, 500, 1'b0));
    send_sample(make_sample(-50, 501, 1'b1));
  endtask

  task automatic test_extreme_codes();
    // most negative code with an out-of-range stamp, then largest positive code
    send_sample(make_sample(-131072, 18'h3FFFF, 1'b0));
    send_sample(make_sample(131071, 0, 1'b1));
  endtask

  // one run: mostly a rise-peak-set curve, otherwise tie-prone small values or noise
  task automatic send_random_run();
    int unsigned n, kind, t, step;
    int          p, top, slope, el, d;
    bit          wild_time;
    n         = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    kind      = $urandom_range(0, 99);
    wild_time = ($urandom_range(0, 9) == 0);
    t         = $urandom_range(0, 235000);
    step      = $urandom_range(1, 60);
    p         = $urandom_range(0, n - 1);
    top       = $urandom_range(0, 110000);
    top       = top - 20000;
    slope     = $urandom_range(1, 40000);
    for (int i = 0; i < n; i++) begin
      if (kind < 65) begin
        d  = (i > p) ? (i - p) : (p - i);
        el = $urandom_range(0, 200);
        el = top - slope * d + el - 100;
        if (el < -90000) el = -90000;
        if (el > 90000) el = 90000;
      end else if (kind < 80) begin
        el = $urandom_range(0, 8);
        el = el - 4;
      end else if (kind < 92) begin
        el = $urandom_range(0, 180000);
        el = el - 90000;
      end else begin
        el = $signed(elev_t'($urandom_range(0, 18'h3FFFF)));
      end
      send_sample(make_sample(el, wild_time ? $urandom_range(0, 18'h3FFFF) : t, i == n - 1));
      t = (t + step) & 18'h3FFFF;
      random_sent++;
    end
  endtask

  task automatic test_random_runs();
    bit paused;
    paused = 1'b0;
    while (random_sent < RANDOM_SAMPLES) begin
      send_random_run();
      // stop feeding once and let every pending result come out
      if (!paused && random_sent >= RANDOM_SAMPLES / 2) begin
        wait_reports_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    clear_run();
    burst_left = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_single_samples();
    test_crossing_ties();
    test_no_crossings();
    test_extreme_codes();
    test_random_runs();
    wait_reports_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d samples and %0d results (%0d with a rise, %0d with a set)",
             samples_taken, reports_checked, rise_reports, set_reports);
    $display("%0d mismatches, %0d results still expected", mismatches, run_reports.size());
    if (mismatches == 0 && run_reports.size() == 0)
      $display("** rise_peak_set_detector_core: PASSED **");
    else
      $display("** rise_peak_set_detector_core: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results still expected", run_reports.size());
    $display("** rise_peak_set_detector_core: FAILED **");
    $finish;
  end

endmodule
